// ===== hdl/mnbs_pkg.sv =====
// Shared types and constants for the minimum-energy block search.
package mnbs_pkg;

  localparam int DEGRID_W = 16;
  localparam int WIN_W    = 16;
  localparam int GAIN_W   = 25;
  localparam int CORR_W   = 32;
  localparam int PSD_W    = 64;
  localparam int SUM_W    = 63;
  localparam int EDGE     = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [DEGRID_W-1:0] DEGRID_RST = 16'hFFFF;
  localparam int                  BLOCKS_RST = 16;

  localparam logic [SUM_W-1:0]         SUM_MAX    = {SUM_W{1'b1}};
  localparam logic signed [GAIN_W-1:0] GAIN_MAX_C = 25'sh0FF_FFFF;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN_C = 25'sh100_0000;
  localparam logic signed [CORR_W-1:0] CORR_MAX_C = 32'sh7FFF_FFFF;
  localparam logic signed [CORR_W-1:0] CORR_MIN_C = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_DEGRID = 2'd0,
    REG_ACROSS = 2'd1,
    REG_DOWN   = 2'd2
  } reg_idx_t;

  // Datapath commands, one step of the bin sequence each
  typedef struct packed {
    logic capture;
    logic num_load;
    logic div_step;
    logic gain_load;
    logic corr_mul;
    logic corr_sub;
    logic square;
    logic psd_add;
    logic wmul;
    logic wsum;
    logic acc;
    logic close;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic grid_zero;
    logic block_end;
    logic frame_end;
  } dp_stat_t;

endpackage

// ===== hdl/mnbs_cfg.sv =====
// Configuration register file behind the APB-style port.
module mnbs_cfg #(
  parameter int INDEX_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mnbs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mnbs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mnbs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [mnbs_pkg::DEGRID_W-1:0]    degrid,
  output logic [INDEX_BITS-1:0]            blocks_across,
  output logic [INDEX_BITS-1:0]            blocks_down
);
  import mnbs_pkg::*;

  logic [DEGRID_W-1:0]   degrid_r;
  logic [INDEX_BITS-1:0] across_r;
  logic [INDEX_BITS-1:0] down_r;
  reg_idx_t              idx;
  logic                  wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degrid_r <= DEGRID_RST;
      across_r <= INDEX_BITS'(BLOCKS_RST);
      down_r   <= INDEX_BITS'(BLOCKS_RST);
    end else if (wr_en) begin
      unique case (idx)
        REG_DEGRID: degrid_r <= pwdata[DEGRID_W-1:0];
        REG_ACROSS: across_r <= pwdata[INDEX_BITS-1:0];
        REG_DOWN:   down_r   <= pwdata[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEGRID: prdata = CFG_DATA_W'(degrid_r);
      REG_ACROSS: prdata = CFG_DATA_W'(across_r);
      REG_DOWN:   prdata = CFG_DATA_W'(down_r);
      default:    prdata = '0;
    endcase
  end

  assign degrid        = degrid_r;
  assign blocks_across = across_r;
  assign blocks_down   = down_r;

endmodule

// ===== hdl/mnbs_dp.sv =====
// Datapath: gain divider, bin correction, weighted energy and block search.
module mnbs_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int INDEX_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mnbs_pkg::dp_cmd_t                   cmd,
  output mnbs_pkg::dp_stat_t                  stat,
  input  logic [mnbs_pkg::DEGRID_W-1:0]       degrid,
  input  logic [INDEX_BITS-1:0]               blocks_across,
  input  logic [INDEX_BITS-1:0]               blocks_down,
  input  logic signed [SAMPLE_BITS-1:0]       in_bin_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_bin_im,
  input  logic signed [SAMPLE_BITS-1:0]       in_grid_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_grid_im,
  input  logic [mnbs_pkg::WIN_W-1:0]          in_window,
  input  logic [INDEX_BITS-1:0]               in_block_col,
  input  logic [INDEX_BITS-1:0]               in_block_row,
  input  logic                                in_last_bin,
  input  logic                                in_last_of_frame,
  output logic [INDEX_BITS-1:0]               out_best_col,
  output logic [INDEX_BITS-1:0]               out_best_row,
  output logic                                out_found,
  output logic [mnbs_pkg::SUM_W-1:0]          out_best_energy
);
  import mnbs_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int NUM_W  = SB + DEGRID_W;
  localparam int QW     = (NUM_W > GAIN_W) ? NUM_W : GAIN_W;
  localparam int PROD_W = GAIN_W + SB;
  localparam int CW     = SB + 10;
  localparam int SW     = (CW > CORR_W + 1) ? CW : CORR_W + 1;
  localparam int IW1    = INDEX_BITS + 1;

  localparam logic [QW-1:0]        NEG_LIM = QW'(1) << (GAIN_W - 1);
  localparam logic [QW-1:0]        POS_LIM = NEG_LIM - QW'(1);
  localparam logic signed [SW-1:0] SAT_HI  = SW'(CORR_MAX_C);
  localparam logic signed [SW-1:0] SAT_LO  = SW'(CORR_MIN_C);

  // captured beat
  logic signed [SB-1:0]  bin_re_r, bin_im_r, grid_re_r, grid_im_r;
  logic [WIN_W-1:0]      win_r;
  logic [INDEX_BITS-1:0] col_r, row_r;
  logic                  last_r, fend_r;

  // gain divider
  logic [NUM_W-1:0]      quo_r;
  logic [SB-1:0]         rem_r;
  logic [SB-1:0]         den_r;
  logic                  qneg_r;
  logic signed [GAIN_W-1:0] gain_r;

  // energy pipeline registers
  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic signed [CORR_W-1:0] cre_r, cim_r;
  logic [SUM_W-1:0]         sq_re_r, sq_im_r;
  logic [PSD_W-1:0]         psd_r;
  logic [39:0]              pa_r, pb_r;
  logic [31:0]              pc_r;
  logic [SUM_W-1:0]         w_r;

  // search state
  logic [SUM_W-1:0]      block_sum_r, best_sum_r;
  logic [INDEX_BITS-1:0] best_col_r, best_row_r;
  logic                  found_r;

  // output register
  logic [INDEX_BITS-1:0] o_col_r, o_row_r;
  logic                  o_found_r;
  logic [SUM_W-1:0]      o_energy_r;

  logic [SB-1:0]            bre_mag, gre_mag;
  logic [SB:0]              rem_sh;
  logic                     div_ge;
  logic [QW-1:0]            q_ext;
  logic signed [GAIN_W-1:0] gain_nxt;
  logic signed [CW-1:0]     diff_re, diff_im;
  logic signed [63:0]       sq_re, sq_im;
  logic [PSD_W-1:0]         w_full;
  logic [PSD_W-1:0]         acc_sum;
  logic                     interior;
  logic [SUM_W-1:0]         best_sum_upd;
  logic [INDEX_BITS-1:0]    best_col_upd, best_row_upd;
  logic                     found_upd;

  function automatic logic signed [CORR_W-1:0] corr_sat(input logic signed [CW-1:0] d);
    logic signed [SW-1:0] x;
    x = SW'(d);
    if (x > SAT_HI)      corr_sat = CORR_MAX_C;
    else if (x < SAT_LO) corr_sat = CORR_MIN_C;
    else                 corr_sat = x[CORR_W-1:0];
  endfunction

  assign stat.grid_zero = (grid_re_r == '0);
  assign stat.block_end = last_r | fend_r;
  assign stat.frame_end = fend_r;

  always_comb begin
    bre_mag = bin_re_r[SB-1]  ? SB'(-bin_re_r)  : SB'(bin_re_r);
    gre_mag = grid_re_r[SB-1] ? SB'(-grid_re_r) : SB'(grid_re_r);
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    div_ge  = (rem_sh >= {1'b0, den_r});
  end

  // quotient is truncated toward zero, then clamped to Q8.16 range
  always_comb begin
    q_ext = QW'(quo_r);
    if (stat.grid_zero)     gain_nxt = '0;
    else if (qneg_r) begin
      if (q_ext >= NEG_LIM) gain_nxt = GAIN_MIN_C;
      else                  gain_nxt = -$signed(q_ext[GAIN_W-1:0]);
    end else begin
      if (q_ext > POS_LIM)  gain_nxt = GAIN_MAX_C;
      else                  gain_nxt = $signed(q_ext[GAIN_W-1:0]);
    end
  end

  // dropping the low 16 product bits is a floor shift in two's complement
  always_comb begin
    diff_re = bin_re_r - $signed(prod_re_r[PROD_W-1:16]);
    diff_im = bin_im_r - $signed(prod_im_r[PROD_W-1:16]);
    sq_re   = cre_r * cre_r;
    sq_im   = cim_r * cim_r;
    w_full  = (PSD_W'(pa_r) << 24) + PSD_W'(pb_r) + PSD_W'(pc_r[31:16]);
    acc_sum = PSD_W'(block_sum_r) + PSD_W'(w_r);
  end

  always_comb begin
    interior = (IW1'(col_r) >= IW1'(EDGE)) && (IW1'(row_r) >= IW1'(EDGE)) &&
               (IW1'(col_r) + IW1'(EDGE) < IW1'(blocks_across)) &&
               (IW1'(row_r) + IW1'(EDGE) < IW1'(blocks_down));
    found_upd    = found_r;
    best_sum_upd = best_sum_r;
    best_col_upd = best_col_r;
    best_row_upd = best_row_r;
    if (interior) begin
      found_upd = 1'b1;
      if (block_sum_r < best_sum_r) begin
        best_sum_upd = block_sum_r;
        best_col_upd = col_r;
        best_row_upd = row_r;
      end
    end
  end

  // beat capture and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin_re_r  <= in_bin_re;
      bin_im_r  <= in_bin_im;
      grid_re_r <= in_grid_re;
      grid_im_r <= in_grid_im;
      win_r     <= in_window;
      col_r     <= in_block_col;
      row_r     <= in_block_row;
      last_r    <= in_last_bin;
      fend_r    <= in_last_of_frame;
    end
    if (cmd.num_load) begin
      quo_r  <= degrid * bre_mag;
      rem_r  <= '0;
      den_r  <= gre_mag;
      qneg_r <= bin_re_r[SB-1] ^ grid_re_r[SB-1];
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? SB'(rem_sh - {1'b0, den_r}) : rem_sh[SB-1:0];
      quo_r <= {quo_r[NUM_W-2:0], div_ge};
    end
    if (cmd.corr_mul) begin
      prod_re_r <= gain_r * grid_re_r;
      prod_im_r <= gain_r * grid_im_r;
    end
    if (cmd.corr_sub) begin
      cre_r <= corr_sat(diff_re);
      cim_r <= corr_sat(diff_im);
    end
    if (cmd.square) begin
      sq_re_r <= sq_re[SUM_W-1:0];
      sq_im_r <= sq_im[SUM_W-1:0];
    end
    if (cmd.psd_add) psd_r <= PSD_W'(sq_re_r) + PSD_W'(sq_im_r);
    if (cmd.wmul) begin
      pa_r <= psd_r[63:40] * win_r;
      pb_r <= psd_r[39:16] * win_r;
      pc_r <= psd_r[15:0] * win_r;
    end
    if (cmd.wsum) w_r <= w_full[SUM_W-1:0];
    if (cmd.publish) begin
      o_col_r    <= best_col_upd;
      o_row_r    <= best_row_upd;
      o_found_r  <= found_upd;
      o_energy_r <= best_sum_upd;
    end
  end

  // architectural search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= '0;
      block_sum_r <= '0;
      best_sum_r  <= SUM_MAX;
      best_col_r  <= '0;
      best_row_r  <= '0;
      found_r     <= 1'b0;
    end else begin
      if (cmd.gain_load) begin
        gain_r      <= gain_nxt;
        block_sum_r <= '0;
      end
      if (cmd.acc) block_sum_r <= acc_sum[PSD_W-1] ? SUM_MAX : acc_sum[SUM_W-1:0];
      if (cmd.close) begin
        block_sum_r <= '0;
        if (fend_r) begin
          best_sum_r <= SUM_MAX;
          best_col_r <= '0;
          best_row_r <= '0;
          found_r    <= 1'b0;
        end else begin
          best_sum_r <= best_sum_upd;
          best_col_r <= best_col_upd;
          best_row_r <= best_row_upd;
          found_r    <= found_upd;
        end
      end
    end
  end

  assign out_best_col    = o_col_r;
  assign out_best_row    = o_row_r;
  assign out_found       = o_found_r;
  assign out_best_energy = o_energy_r;

endmodule

// ===== hdl/mnbs_ctrl.sv =====
// Sequencer for one bin beat: gain divide, correction, energy, block close.
module mnbs_ctrl #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_first_bin,
  output logic               in_stall,
  output mnbs_pkg::dp_cmd_t  cmd,
  input  mnbs_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall
);
  import mnbs_pkg::*;

  localparam int NUM_W = SAMPLE_BITS + DEGRID_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MULN, S_DIV, S_GAIN, S_CMUL, S_CSUB,
    S_SQR, S_PSD, S_WMUL, S_WSUM, S_ACC, S_CLOSE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = in_first_bin ? S_MULN : S_CMUL;
      S_MULN:  state_nxt = stat.grid_zero ? S_GAIN : S_DIV;
      S_DIV:   if (cnt_r == LAST_STEP) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_CMUL;
      S_CMUL:  state_nxt = S_CSUB;
      S_CSUB:  state_nxt = S_SQR;
      S_SQR:   state_nxt = S_PSD;
      S_PSD:   state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_WSUM;
      S_WSUM:  state_nxt = S_ACC;
      S_ACC:   state_nxt = stat.block_end ? S_CLOSE : S_IDLE;
      S_CLOSE: if (!stat.frame_end || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.capture   = in_valid;
      S_MULN:  cmd.num_load  = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_GAIN:  cmd.gain_load = 1'b1;
      S_CMUL:  cmd.corr_mul  = 1'b1;
      S_CSUB:  cmd.corr_sub  = 1'b1;
      S_SQR:   cmd.square    = 1'b1;
      S_PSD:   cmd.psd_add   = 1'b1;
      S_WMUL:  cmd.wmul      = 1'b1;
      S_WSUM:  cmd.wsum      = 1'b1;
      S_ACC:   cmd.acc       = 1'b1;
      S_CLOSE: begin
        // frame end holds here until the result register is free
        cmd.close   = !stat.frame_end || out_free;
        cmd.publish = stat.frame_end && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV) cnt_r <= cnt_r + CNT_W'(1);
      else                  cnt_r <= '0;
      if (cmd.publish)   out_valid_r <= 1'b1;
      else if (out_free) out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/min_noise_block_search.sv =====
// Minimum-energy block search: top level.
//
// Bins are taken one beat at a time, and a beat is held in the block until
// its energy is summed. An ordinary bin passes the states S_CMUL to S_ACC
// before the next accept, and S_CLOSE too when it closes a block. A bin that
// starts a block first forms the grid gain (S_MULN, S_DIV, S_GAIN) with a
// restoring divider that resolves one quotient bit a cycle; S_DIV is skipped
// when the grid sample's real part is zero. The frame result sits in an
// output register; a frame end waits only while a previous result is still
// stalled there. Registers: degrid at 0x0, blocks_across at 0x4,
// blocks_down at 0x8; write them only while the block is idle.
module min_noise_block_search #(
  parameter int SAMPLE_BITS = 24,
  parameter int INDEX_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_bin_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_bin_im,
  input  logic signed [SAMPLE_BITS-1:0]       in_grid_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_grid_im,
  input  logic [mnbs_pkg::WIN_W-1:0]          in_window,
  input  logic [INDEX_BITS-1:0]               in_block_col,
  input  logic [INDEX_BITS-1:0]               in_block_row,
  input  logic                                in_first_bin,
  input  logic                                in_last_bin,
  input  logic                                in_last_of_frame,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [INDEX_BITS-1:0]               out_best_col,
  output logic [INDEX_BITS-1:0]               out_best_row,
  output logic                                out_found,
  output logic [mnbs_pkg::SUM_W-1:0]          out_best_energy,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mnbs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mnbs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mnbs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mnbs_pkg::*;

  logic [DEGRID_W-1:0]   degrid;
  logic [INDEX_BITS-1:0] blocks_across;
  logic [INDEX_BITS-1:0] blocks_down;
  dp_cmd_t               cmd;
  dp_stat_t              stat;

  mnbs_cfg #(
    .INDEX_BITS (INDEX_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .degrid        (degrid),
    .blocks_across (blocks_across),
    .blocks_down   (blocks_down)
  );

  mnbs_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_first_bin (in_first_bin),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  mnbs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .degrid           (degrid),
    .blocks_across    (blocks_across),
    .blocks_down      (blocks_down),
    .in_bin_re        (in_bin_re),
    .in_bin_im        (in_bin_im),
    .in_grid_re       (in_grid_re),
    .in_grid_im       (in_grid_im),
    .in_window        (in_window),
    .in_block_col     (in_block_col),
    .in_block_row     (in_block_row),
    .in_last_bin      (in_last_bin),
    .in_last_of_frame (in_last_of_frame),
    .out_best_col     (out_best_col),
    .out_best_row     (out_best_row),
    .out_found        (out_found),
    .out_best_energy  (out_best_energy)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the minimum-energy block search.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnbs_pkg::*;

  localparam int SB            = 24;
  localparam int IB            = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int STUCK_LIMIT   = 1000;
  localparam int PHASES        = 8;
  localparam int PHASE_BINS    = 88;
  localparam longint GAIN_HI   = 64'sd16777215;
  localparam longint GAIN_LO   = -64'sd16777216;
  localparam longint CORR_HI   = 64'sd2147483647;
  localparam longint CORR_LO   = -64'sd2147483648;

  typedef struct {
    logic signed [SB-1:0] bre;
    logic signed [SB-1:0] bim;
    logic signed [SB-1:0] gre;
    logic signed [SB-1:0] gim;
    logic [WIN_W-1:0]     win;
    logic [IB-1:0]        col;
    logic [IB-1:0]        row;
    logic                 first;
    logic                 last;
    logic                 lof;
  } bin_t;

  typedef struct {
    bit [IB-1:0]    col;
    bit [IB-1:0]    row;
    bit             found;
    bit [SUM_W-1:0] energy;
  } frame_result_t;

  typedef struct {
    bit            is_cfg;
    reg_idx_t      ridx;
    bit [31:0]     val;
    bin_t          b;
    bit            typed;
    frame_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_bin_re = '0;
  logic signed [SB-1:0] in_bin_im = '0;
  logic signed [SB-1:0] in_grid_re = '0;
  logic signed [SB-1:0] in_grid_im = '0;
  logic [WIN_W-1:0] in_window = '0;
  logic [IB-1:0] in_block_col = '0;
  logic [IB-1:0] in_block_row = '0;
  logic in_first_bin = 1'b0;
  logic in_last_bin = 1'b0;
  logic in_last_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IB-1:0] out_best_col;
  logic [IB-1:0] out_best_row;
  logic out_found;
  logic [SUM_W-1:0] out_best_energy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  min_noise_block_search #(.SAMPLE_BITS(SB), .INDEX_BITS(IB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_bin_re(in_bin_re), .in_bin_im(in_bin_im),
    .in_grid_re(in_grid_re), .in_grid_im(in_grid_im),
    .in_window(in_window), .in_block_col(in_block_col), .in_block_row(in_block_row),
    .in_first_bin(in_first_bin), .in_last_bin(in_last_bin),
    .in_last_of_frame(in_last_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_best_col(out_best_col), .out_best_row(out_best_row),
    .out_found(out_found), .out_best_energy(out_best_energy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // search model state
  bit [15:0]      cfg_degrid = 16'hFFFF;
  bit [IB-1:0]    cfg_across = 8'd16;
  bit [IB-1:0]    cfg_down   = 8'd16;
  longint         gain_q     = 0;
  bit [SUM_W-1:0] blk_energy = '0;
  bit [SUM_W-1:0] lead_energy = SUM_MAX;
  bit [IB-1:0]    lead_col = '0;
  bit [IB-1:0]    lead_row = '0;
  bit             seen_interior = 1'b0;

  frame_result_t pending_frames[$];
  int mismatch_cnt = 0;
  int stuck_cycles = 0;
  int hold_left = 0;
  bit idling = 1'b0;

  function automatic longint corrected(longint smp, longint grid);
    longint c;
    c = smp - ((gain_q * grid) >>> 16);
    if (c > CORR_HI) c = CORR_HI;
    if (c < CORR_LO) c = CORR_LO;
    return c;
  endfunction

  function automatic bit [63:0] mag2(longint c);
    bit [63:0] a;
    a = (c < 0) ? 64'(-c) : 64'(c);
    return a * a;
  endfunction

  // one bin through the search; returns 1 when a frame result falls out
  function automatic bit search_step(input bin_t b, output frame_result_t r);
    longint bre, bim, gre, gim, g;
    bit [63:0] psd;
    bit [79:0] prod;
    bit [64:0] s;
    bit interior;
    bre = b.bre;
    bim = b.bim;
    gre = b.gre;
    gim = b.gim;
    r = '{default: 0};
    if (b.first) begin
      g = 0;
      if (gre != 0) begin
        g = (longint'(cfg_degrid) * bre) / gre;
        if (g > GAIN_HI) g = GAIN_HI;
        if (g < GAIN_LO) g = GAIN_LO;
      end
      gain_q = g;
      blk_energy = '0;
    end
    psd = mag2(corrected(bre, gre)) + mag2(corrected(bim, gim));
    prod = 80'(psd) * 80'(b.win);
    s = 65'(blk_energy) + 65'(prod[79:16]);
    blk_energy = (s > 65'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    if (b.last || b.lof) begin
      interior = int'(b.col) >= EDGE && int'(b.row) >= EDGE &&
                 int'(b.col) + EDGE < int'(cfg_across) &&
                 int'(b.row) + EDGE < int'(cfg_down);
      if (interior) begin
        seen_interior = 1'b1;
        if (blk_energy < lead_energy) begin
          lead_energy = blk_energy;
          lead_col = b.col;
          lead_row = b.row;
        end
      end
      blk_energy = '0;
    end
    if (b.lof) begin
      r.col = lead_col;
      r.row = lead_row;
      r.found = seen_interior;
      r.energy = lead_energy;
      blk_energy = '0;
      lead_energy = SUM_MAX;
      lead_col = '0;
      lead_row = '0;
      seen_interior = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report("result beat with nothing pending", out_best_energy, 0);
      end else begin
        e = pending_frames.pop_front();
        if (out_best_col !== e.col) report("best_col", out_best_col, e.col);
        if (out_best_row !== e.row) report("best_row", out_best_row, e.row);
        if (out_found !== e.found) report("found", out_found, e.found);
        if (out_best_energy !== e.energy) report("best_energy", out_best_energy, e.energy);
      end
    end
  end

  // result-side backpressure bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("min_noise_block_search test failed");
        $finish;
      end
    end
  end

  task automatic send_bin(input bin_t b, input bit typed, input frame_result_t typed_res);
    frame_result_t r;
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_bin_re        <= b.bre;
    in_bin_im        <= b.bim;
    in_grid_re       <= b.gre;
    in_grid_im       <= b.gim;
    in_window        <= b.win;
    in_block_col     <= b.col;
    in_block_row     <= b.row;
    in_first_bin     <= b.first;
    in_last_bin      <= b.last;
    in_last_of_frame <= b.lof;
    do @(posedge clk); while (in_stall);
    if (search_step(b, r)) pending_frames.push_back(typed ? typed_res : r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input bit [31:0] v);
    logic [CFG_ADDR_W-1:0] a;
    a = CFG_ADDR_W'(4 * int'(r));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DEGRID: cfg_degrid = v[15:0];
      REG_ACROSS: cfg_across = v[IB-1:0];
      REG_DOWN:   cfg_down   = v[IB-1:0];
      default: ;
    endcase
    // bus returns to idle between transfers
    @(posedge clk);
  endtask

  function automatic dir_row_t bin_row(longint re, longint im, longint gre, longint gim,
                                       int win, int col, int row, bit f, bit l, bit e);
    dir_row_t d;
    d = '{ridx: REG_DEGRID, default: 0};
    d.b.bre = SB'(re);
    d.b.bim = SB'(im);
    d.b.gre = SB'(gre);
    d.b.gim = SB'(gim);
    d.b.win = WIN_W'(win);
    d.b.col = IB'(col);
    d.b.row = IB'(row);
    d.b.first = f;
    d.b.last = l;
    d.b.lof = e;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(reg_idx_t r, int v);
    dir_row_t d;
    d = '{ridx: REG_DEGRID, default: 0};
    d.is_cfg = 1'b1;
    d.ridx = r;
    d.val = v;
    return d;
  endfunction

  function automatic dir_row_t with_result(dir_row_t d, int col, int row, bit found,
                                           bit [SUM_W-1:0] energy);
    d.typed = 1'b1;
    d.res.col = IB'(col);
    d.res.row = IB'(row);
    d.res.found = found;
    d.res.energy = energy;
    return d;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] v;
    v = SB'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: v = v >>> $urandom_range(1, SB - 1);
      2: v = '0;
      default: v = $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
    endcase
    return v;
  endfunction

  function automatic logic [WIN_W-1:0] rand_window();
    case ($urandom_range(0, 3))
      0: return WIN_W'($urandom);
      1: return '1;
      2: return '0;
      default: return WIN_W'($urandom) >> $urandom_range(1, WIN_W - 1);
    endcase
  endfunction

  // mostly inside the interior, sometimes anywhere in range
  function automatic logic [IB-1:0] pick_index(bit [IB-1:0] n);
    if (n > 2 * EDGE && $urandom_range(0, 4) != 0)
      return IB'($urandom_range(EDGE, int'(n) - 1 - EDGE));
    return IB'($urandom_range(0, 254));
  endfunction

  task automatic run_frame(inout int count);
    int nblk, nbins;
    bin_t b;
    logic [IB-1:0] col, row;
    frame_result_t none;
    none = '{default: 0};
    nblk = $urandom_range(1, 5);
    for (int k = 0; k < nblk; k++) begin
      col = pick_index(cfg_across);
      row = pick_index(cfg_down);
      nbins = $urandom_range(1, 4);
      for (int i = 0; i < nbins; i++) begin
        b.bre = rand_sample();
        b.bim = rand_sample();
        b.gre = rand_sample();
        b.gim = rand_sample();
        b.win = rand_window();
        b.col = col;
        b.row = row;
        b.first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        if (b.first && $urandom_range(0, 5) == 0) b.gre = '0;
        b.lof = (k == nblk - 1) && (i == nbins - 1);
        if (i != nbins - 1) b.last = ($urandom_range(0, 24) == 0);
        else if (b.lof) b.last = $urandom_range(0, 1);
        else b.last = ($urandom_range(0, 9) != 0);
        send_bin(b, 1'b0, none);
        count++;
      end
    end
  endtask

  initial begin
    dir_row_t rows[$];
    int ph_degrid[PHASES] = '{65535, 0, 65535, 40000, -1, 1, -1, -1};
    int ph_across[PHASES] = '{16, 255, 1, 5, 255, 4, -1, -1};
    int ph_down[PHASES]   = '{16, 255, 1, 5, 6, 4, -1, -1};
    int count;

    // held gain before any first bin, frame end without last bin
    rows.push_back(with_result(bin_row(100, -50, 7, 3, 16'hFFFF, 0, 0, 0, 0, 1),
                               0, 0, 0, SUM_MAX));
    // zero grid sample gives zero gain; ties keep the first lead
    rows.push_back(bin_row(0, 0, 0, 0, 16'hFFFF, 5, 5, 1, 1, 0));
    rows.push_back(bin_row(0, 0, 0, 0, 16'h1234, 4, 4, 1, 1, 0));
    rows.push_back(with_result(bin_row(1, 1, 0, 0, 0, 6, 6, 0, 1, 1), 5, 5, 1, 0));
    // gain saturates high, sum saturates, interior seen with no lead
    rows.push_back(bin_row(8388607, -8388608, 1, -8388608, 16'hFFFF, 2, 2, 1, 0, 0));
    rows.push_back(bin_row(-8388608, 8388607, 8388607, 8388607, 16'hFFFF, 2, 2, 0, 1, 0));
    rows.push_back(bin_row(0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 1));
    // gain is kept across frames
    rows.push_back(bin_row(1000, 1000, 300, -300, 16'h8000, 7, 7, 0, 1, 1));
    // gain saturates low, edge blocks, index extremes
    rows.push_back(bin_row(-8388608, 0, 1, 0, 16'hFFFF, 13, 13, 1, 1, 0));
    rows.push_back(bin_row(300, -7, 2, 5, 16'h0001, 14, 5, 1, 1, 0));
    rows.push_back(bin_row(-3, 4, -2, 1, 16'h7FFF, 5, 1, 1, 1, 0));
    rows.push_back(bin_row(12, 34, 56, 78, 16'hFFFF, 254, 254, 1, 0, 0));
    rows.push_back(bin_row(-12, -34, -56, -78, 16'h00FF, 254, 254, 0, 0, 0));
    rows.push_back(bin_row(8388607, 8388607, -8388608, -8388608, 16'hFFFF, 254, 254, 0, 1, 1));
    rows.push_back(cfg_row(REG_DEGRID, 0));
    rows.push_back(bin_row(8388607, -8388608, 3, 3, 16'hFFFF, 9, 9, 1, 1, 1));
    // small frame: nothing is interior
    rows.push_back(cfg_row(REG_ACROSS, 4));
    rows.push_back(cfg_row(REG_DOWN, 4));
    rows.push_back(with_result(bin_row(0, 0, 0, 0, 0, 2, 2, 1, 1, 1), 0, 0, 0, SUM_MAX));
    rows.push_back(cfg_row(REG_ACROSS, 16));
    rows.push_back(cfg_row(REG_DOWN, 16));
    rows.push_back(cfg_row(REG_DEGRID, 65535));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        cfg_write(rows[i].ridx, rows[i].val);
      end else begin
        send_bin(rows[i].b, rows[i].typed, rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      cfg_write(REG_DEGRID, ph_degrid[ph] < 0 ? $urandom_range(0, 65535) : ph_degrid[ph]);
      cfg_write(REG_ACROSS, ph_across[ph] < 0 ?
                $urandom_range(5, ph == PHASES - 1 ? 12 : 40) : ph_across[ph]);
      cfg_write(REG_DOWN, ph_down[ph] < 0 ?
                $urandom_range(5, ph == PHASES - 1 ? 12 : 40) : ph_down[ph]);
      count = 0;
      while (count < PHASE_BINS) begin
        // last phase runs at full rate on both sides
        idling = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
        run_frame(count);
      end
    end

    idling = 1'b0;
    settle();
    if (mismatch_cnt == 0) begin
      $display("min_noise_block_search test passed");
    end else begin
      $display("min_noise_block_search test failed");
    end
    $finish;
  end

endmodule
